// ===== design/cstc_pkg.sv =====
package cstc_pkg;

	// Widths of the stream and configuration ports
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// Field and state widths
	localparam int MIX_W = 21;
	localparam int SAMPLE_W = 16;
	localparam int COEFF_W = 30;
	localparam int SEED_W = 29;
	localparam int VOL_W = 20;
	localparam int STEP_W = 18;
	localparam int TIME_W = 32;
	localparam int CLOCK_W = 48;
	localparam int OSC_W = 32;

	// Oscillator scaling: the product is divided by 8192 (a shift) and then by 32767
	localparam int PROD_W = COEFF_W + OSC_W;
	localparam int DIV_SHIFT = 13;
	localparam int DIV_STEPS = PROD_W - DIV_SHIFT;
	localparam int OSC_SCALE = 32767;
	localparam int DREM_W = 15;
	localparam int SER_STEPS = 32;
	localparam int CNT_W = 6;

	// Mix arithmetic and saturation limits
	localparam int SUM_W = 34;
	localparam int SAT_MAX = 32767;
	localparam int SAT_MIN = -32768;

	// Register reset values
	localparam int VOL_RESET = 8192;
	localparam int STEP_RESET = 128000;
	localparam int CADENCE_RESET = 1000000;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEFF    = 3'd0,
		REG_SEED     = 3'd1,
		REG_VOLUME   = 3'd2,
		REG_STEP     = 3'd3,
		REG_START    = 3'd4,
		REG_PERIOD   = 3'd5,
		REG_PLAY     = 3'd6,
		REG_DURATION = 3'd7
	} reg_idx_t;

	// Sequencer states
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_END  = 7'b0000010,
		ST_WIN  = 7'b0000100,
		ST_SER  = 7'b0001000,
		ST_CHK  = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

endpackage

// ===== design/cadenced_sine_tone_channel.sv =====
// The sequencer checks the end time and the play window; for an active tone it then runs the
// 32-step serial cadence modulo (beside the serial multiplier and volume divider) and, inside
// the play window, the 49-step serial division by 32767. It waits to load the output register
// while that still holds an untaken result, and takes no new input until it has loaded it.
// Reset (arst_n low) returns the configuration registers to their reset values, clears the
// sample clock, end flag and oscillator, and empties the output register; no clearing pass follows.
module cadenced_sine_tone_channel #(
	parameter int TIME_FRACTION_BITS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata: mix_in [20:0], zero padding [23:21]
	input  logic [cstc_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata: sample_out [15:0]
	output logic [cstc_pkg::M_TDATA_W-1:0]   m_tdata,
	// m_tuser: clipped [0], tone_sounding [1], tone_finished [2]
	output logic [cstc_pkg::M_TUSER_W-1:0]   m_tuser,
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [cstc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cstc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import cstc_pkg::*;

	localparam int EW = TIME_W + 1 + TIME_FRACTION_BITS;
	localparam int CMPW = (EW > CLOCK_W) ? EW : CLOCK_W;
	localparam logic [CLOCK_W-1:0] FRAME_MASK =
		((CLOCK_W'(1) << TIME_W) - CLOCK_W'(1)) << TIME_FRACTION_BITS;

	// Configuration registers
	logic signed [COEFF_W-1:0] coeff_q;
	logic [VOL_W-1:0]          vol_q;
	logic [STEP_W-1:0]         step_q;
	logic [TIME_W-1:0]         start_q;
	logic [TIME_W-1:0]         period_q;
	logic [TIME_W-1:0]         play_q;
	logic [TIME_W-1:0]         dur_q;

	// Channel state
	logic [CLOCK_W-1:0]        clock_q;
	logic signed [OSC_W-1:0]   older_q;
	logic signed [OSC_W-1:0]   newer_q;
	logic                      ended_q;

	// Sequencer and captured input
	state_t                    state_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [MIX_W-1:0]          mix_q;
	logic                      fend_q;
	logic                      snd_q;

	// Serial units
	logic [TIME_W-1:0]         mrem_q;
	logic [TIME_W-1:0]         mdvd_q;
	logic [PROD_W-1:0]         prod_q;
	logic [COEFF_W-1:0]        mcand_q;
	logic [VOL_W-1:0]          vrem_q;
	logic [OSC_W-1:0]          vdvd_q;
	logic [DREM_W-1:0]         drem_q;
	logic [OSC_W-1:0]          dquo_q;
	logic                      pneg_q;
	logic                      vneg_q;

	// Output register
	logic                      m_tvalid_q;
	logic [SAMPLE_W-1:0]       sample_q;
	logic                      clip_q;
	logic                      sounding_q;
	logic                      finished_q;
	logic                      last_q;

	logic                      in_fire;
	logic                      out_free;
	logic                      fin_fire;

	logic [TIME_W:0]           end_sum;
	logic [CMPW-1:0]           end_c;
	logic [CMPW-1:0]           t_c;
	logic                      end_hit;
	logic [CLOCK_W-1:0]        start_c;
	logic [CLOCK_W-1:0]        diff_c;
	logic [TIME_W-1:0]         abst;
	logic                      active;
	logic [OSC_W-1:0]          newer_mag;
	logic [COEFF_W-1:0]        coeff_mag;

	logic [TIME_W:0]           mr_sh;
	logic                      mr_ge;
	logic [TIME_W:0]           mr_sub;
	logic [VOL_W:0]            vr_sh;
	logic                      vr_ge;
	logic [VOL_W:0]            vr_sub;
	logic [COEFF_W:0]          mul_add;
	logic [DREM_W:0]           dr_sh;
	logic                      dr_ge;
	logic [DREM_W:0]           dr_sub;

	logic [OSC_W-1:0]          q32;
	logic [OSC_W-1:0]          osc_next;
	logic signed [SUM_W-1:0]   vterm;
	logic signed [SUM_W-1:0]   sum;
	logic                      sat_hi;
	logic                      sat_lo;
	logic [SAMPLE_W-1:0]       sample_c;
	logic [CLOCK_W-1:0]        clock_inc;
	logic [CLOCK_W-1:0]        clock_next;

	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign fin_fire = (state_q == ST_FIN) && out_free;
	assign s_tready = (state_q == ST_IDLE);

	// End time and play window of the current clock
	assign end_sum   = {1'b0, start_q} + {1'b0, dur_q};
	assign end_c     = CMPW'(end_sum) << TIME_FRACTION_BITS;
	assign t_c       = CMPW'(clock_q);
	assign end_hit   = !ended_q && (dur_q != '0) && (end_c < t_c);
	assign start_c   = CLOCK_W'(start_q) << TIME_FRACTION_BITS;
	assign diff_c    = clock_q - start_c;
	assign abst      = diff_c[TIME_FRACTION_BITS +: TIME_W];
	assign active    = !ended_q && (clock_q > start_c);
	assign newer_mag = newer_q[OSC_W-1] ? OSC_W'(-newer_q) : OSC_W'(newer_q);
	assign coeff_mag = coeff_q[COEFF_W-1] ? COEFF_W'(-coeff_q) : COEFF_W'(coeff_q);

	// One step of each serial unit
	always_comb begin
		mr_sh   = {mrem_q, mdvd_q[TIME_W-1]};
		mr_ge   = mr_sh >= {1'b0, period_q};
		mr_sub  = mr_sh - {1'b0, period_q};
		vr_sh   = {vrem_q, vdvd_q[OSC_W-1]};
		vr_ge   = vr_sh >= {1'b0, vol_q};
		vr_sub  = vr_sh - {1'b0, vol_q};
		mul_add = {1'b0, prod_q[PROD_W-1:OSC_W]} +
			(prod_q[0] ? {1'b0, mcand_q} : {(COEFF_W+1){1'b0}});
		dr_sh   = {drem_q, prod_q[PROD_W-1]};
		dr_ge   = dr_sh >= (DREM_W+1)'(OSC_SCALE);
		dr_sub  = dr_sh - (DREM_W+1)'(OSC_SCALE);
	end

	// Oscillator recursion result, volume term, mix and saturation
	always_comb begin
		q32      = pneg_q ? OSC_W'(-dquo_q) : dquo_q;
		osc_next = q32 - OSC_W'(older_q);
		if (snd_q && (vol_q != '0)) begin
			vterm = vneg_q ? -$signed(SUM_W'(vdvd_q)) : $signed(SUM_W'(vdvd_q));
		end else begin
			vterm = '0;
		end
		sum    = SUM_W'($signed(mix_q)) + vterm;
		sat_hi = sum > SUM_W'(SAT_MAX);
		sat_lo = sum < SUM_W'(SAT_MIN);
		if (sat_hi) begin
			sample_c = SAMPLE_W'(SAT_MAX);
		end else if (sat_lo) begin
			sample_c = SAMPLE_W'(SAT_MIN);
		end else begin
			sample_c = sum[SAMPLE_W-1:0];
		end
		clock_inc  = clock_q + CLOCK_W'(step_q);
		clock_next = fend_q ? (clock_inc & FRAME_MASK) : clock_inc;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q  <= '0;
			vol_q    <= VOL_W'(VOL_RESET);
			step_q   <= STEP_W'(STEP_RESET);
			start_q  <= '0;
			period_q <= TIME_W'(CADENCE_RESET);
			play_q   <= TIME_W'(CADENCE_RESET);
			dur_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEFF:    coeff_q  <= cfg_data[COEFF_W-1:0];
				REG_VOLUME:   vol_q    <= cfg_data[VOL_W-1:0];
				REG_STEP:     step_q   <= cfg_data[STEP_W-1:0];
				REG_START:    start_q  <= cfg_data[TIME_W-1:0];
				REG_PERIOD:   period_q <= cfg_data[TIME_W-1:0];
				REG_PLAY:     play_q   <= cfg_data[TIME_W-1:0];
				REG_DURATION: dur_q    <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Oscillator state: a seed write restarts it, a sounding sample advances it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q <= '0;
			newer_q <= '0;
		end else if (cfg_we && (cfg_index == REG_SEED)) begin
			older_q <= OSC_W'($signed(cfg_data[SEED_W-1:0]));
			newer_q <= '0;
		end else if (fin_fire && snd_q) begin
			older_q <= newer_q;
			newer_q <= osc_next;
		end
	end

	// Sample clock and end flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
			ended_q <= 1'b0;
		end else begin
			if (state_q == ST_END && end_hit) begin
				ended_q <= 1'b1;
			end
			if (fin_fire) begin
				clock_q <= clock_next;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			snd_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_END;
					end
				end
				ST_END: begin
					state_q <= ST_WIN;
				end
				ST_WIN: begin
					cnt_q <= '0;
					snd_q <= 1'b0;
					state_q <= active ? ST_SER : ST_FIN;
				end
				ST_SER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SER_STEPS - 1)) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					cnt_q <= '0;
					snd_q <= mrem_q < play_q;
					state_q <= (mrem_q < play_q) ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Input capture and the serial datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mix_q  <= s_tdata[MIX_W-1:0];
			fend_q <= s_tlast;
		end
		case (state_q)
			ST_WIN: begin
				mrem_q  <= '0;
				mdvd_q  <= abst;
				prod_q  <= PROD_W'(newer_mag);
				mcand_q <= coeff_mag;
				vrem_q  <= '0;
				vdvd_q  <= newer_mag;
				pneg_q  <= coeff_q[COEFF_W-1] ^ newer_q[OSC_W-1];
				vneg_q  <= newer_q[OSC_W-1];
			end
			ST_SER: begin
				mrem_q <= mr_ge ? mr_sub[TIME_W-1:0] : mr_sh[TIME_W-1:0];
				mdvd_q <= {mdvd_q[TIME_W-2:0], 1'b0};
				vrem_q <= vr_ge ? vr_sub[VOL_W-1:0] : vr_sh[VOL_W-1:0];
				vdvd_q <= {vdvd_q[OSC_W-2:0], vr_ge};
				prod_q <= {mul_add, prod_q[OSC_W-1:1]};
			end
			ST_CHK: begin
				drem_q <= '0;
			end
			ST_DIV: begin
				drem_q <= dr_ge ? dr_sub[DREM_W-1:0] : dr_sh[DREM_W-1:0];
				dquo_q <= {dquo_q[OSC_W-2:0], dr_ge};
				prod_q <= {prod_q[PROD_W-2:0], 1'b0};
			end
			default: ;
		endcase
	end

	// Output register, free to take a new result as soon as the old one is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fin_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			sample_q   <= sample_c;
			clip_q     <= sat_hi || sat_lo;
			sounding_q <= snd_q;
			finished_q <= ended_q;
			last_q     <= fend_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = sample_q;
	assign m_tuser  = {finished_q, sounding_q, clip_q};
	assign m_tlast  = last_q;

endmodule

// ===== test/cadenced_sine_tone_channel_tb.sv =====
`timescale 1ns / 100ps

module cadenced_sine_tone_channel_tb;
	import cstc_pkg::*;

	localparam int FRAC_BITS = 10;
	// Recursion divisor: 32767 * 8192.
	localparam longint OSC_DIVISOR = 268427264;
	localparam longint COEFF_PEAK = 536854528;
	localparam longint SEED_PEAK = 268427264;
	localparam int VOL_PEAK = 819200;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 100;
	localparam int PHASE_ITEMS = 80;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] level;
		logic clipped;
		logic sounding;
		logic finished;
		logic frame_last;
	} mixed_sample_t;

	// Tracks the tone channel: registers, sample clock and oscillator, and the
	// mixed samples still owed by the block.
	class tone_mix_tracker;
		longint coeff, seed, older, newer;
		logic [VOL_W-1:0] vol_div;
		logic [STEP_W-1:0] time_step;
		logic [TIME_W-1:0] start_us, period_us, play_us, length_us;
		logic [CLOCK_W-1:0] clock;
		bit tone_over;
		mixed_sample_t samples_due[$];
		int unsigned fail_count;

		function new();
			coeff = 0;
			seed = 0;
			older = 0;
			newer = 0;
			vol_div = VOL_RESET;
			time_step = STEP_RESET;
			start_us = '0;
			period_us = CADENCE_RESET;
			play_us = CADENCE_RESET;
			length_us = '0;
			clock = '0;
			tone_over = 1'b0;
			fail_count = 0;
		endfunction

		function void apply_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_COEFF: coeff = longint'($signed(value[COEFF_W-1:0]));
				REG_SEED: begin
					// A new seed restarts the oscillator.
					seed = longint'($signed(value[SEED_W-1:0]));
					older = seed;
					newer = 0;
				end
				REG_VOLUME: vol_div = value[VOL_W-1:0];
				REG_STEP: time_step = value[STEP_W-1:0];
				REG_START: start_us = value[TIME_W-1:0];
				REG_PERIOD: period_us = value[TIME_W-1:0];
				REG_PLAY: play_us = value[TIME_W-1:0];
				REG_DURATION: length_us = value[TIME_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic [MIX_W-1:0] mix_bits, logic frame_end);
			logic [63:0] t, start_w, end_w, abst, relt;
			logic [OSC_W-1:0] next_bits;
			longint total, quot;
			mixed_sample_t r;
			r.clipped = 1'b0;
			r.sounding = 1'b0;
			total = longint'($signed(mix_bits));
			t = {16'd0, clock};
			start_w = {32'd0, start_us} << FRAC_BITS;
			end_w = start_w + ({32'd0, length_us} << FRAC_BITS);

			// The tone ends for good once its end time lies behind the clock.
			if (!tone_over && length_us != 0 && end_w < t)
				tone_over = 1'b1;

			// Past the start, the oscillator advances only inside the play window.
			if (!tone_over && t > start_w) begin
				abst = ((t - start_w) >> FRAC_BITS) & 64'hFFFF_FFFF;
				relt = (period_us != 0) ? abst % {32'd0, period_us} : abst;
				if (relt < {32'd0, play_us}) begin
					quot = (coeff * newer) / OSC_DIVISOR;
					next_bits = OSC_W'(quot - older);
					older = newer;
					newer = longint'($signed(next_bits));
					if (vol_div != 0)
						total = total + older / longint'(vol_div);
					r.sounding = 1'b1;
				end
			end

			// Saturate the mix to 16 bits.
			if (total > SAT_MAX) begin
				total = SAT_MAX;
				r.clipped = 1'b1;
			end else if (total < SAT_MIN) begin
				total = SAT_MIN;
				r.clipped = 1'b1;
			end

			// Advance the clock; a frame end drops the fraction bits.
			t = t + {46'd0, time_step};
			t = t & 64'h0000_FFFF_FFFF_FFFF;
			if (frame_end)
				t = ((t >> FRAC_BITS) & 64'hFFFF_FFFF) << FRAC_BITS;
			clock = t[CLOCK_W-1:0];

			r.level = SAMPLE_W'(total);
			r.finished = tone_over;
			r.frame_last = frame_end;
			samples_due.push_back(r);
		endfunction

		function void check_sample(logic [SAMPLE_W-1:0] level, logic [M_TUSER_W-1:0] flags,
				logic frame_last);
			mixed_sample_t want;
			if (samples_due.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected sample %0d flags %b last %b", $time,
					$signed(level), flags, frame_last);
				return;
			end
			want = samples_due.pop_front();
			if (level !== want.level || flags[0] !== want.clipped
					|| flags[1] !== want.sounding || flags[2] !== want.finished
					|| frame_last !== want.frame_last) begin
				fail_count++;
				$display("%0t: expected %0d c%b s%b f%b l%b, got %0d c%b s%b f%b l%b",
					$time, want.level, want.clipped, want.sounding, want.finished,
					want.frame_last, $signed(level), flags[0], flags[1], flags[2],
					frame_last);
			end
		endfunction

		function int pending();
			return samples_due.size();
		endfunction

		function logic [TIME_W-1:0] clock_us();
			return clock[FRAC_BITS +: TIME_W];
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic m_tlast;
	logic cfg_we;
	reg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tone_mix_tracker tracker;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;

	cadenced_sine_tone_channel #(
		.TIME_FRACTION_BITS(FRAC_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock with a 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The receiver stalls at random at each falling edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Both transaction monitors and the watchdog work at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.note_sample(s_tdata[MIX_W-1:0], s_tlast);
			if (m_tvalid && m_tready)
				tracker.check_sample(m_tdata, m_tuser, m_tlast);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				idle_pct = 66;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				idle_pct = 0;
				stall_pct = 66;
			end
			default: begin
				idle_pct = 31;
				stall_pct = 31;
			end
		endcase
	endtask

	task automatic program_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		tracker.apply_reg(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_tone(input longint coeff, input longint seed, input bit with_seed,
			input logic [31:0] vol, input logic [31:0] step_v, input logic [31:0] start_v,
			input logic [31:0] period_v, input logic [31:0] play_v, input logic [31:0] dur_v);
		program_reg(REG_COEFF, CFG_DATA_W'(coeff));
		if (with_seed)
			program_reg(REG_SEED, CFG_DATA_W'(seed));
		program_reg(REG_VOLUME, vol);
		program_reg(REG_STEP, step_v);
		program_reg(REG_START, start_v);
		program_reg(REG_PERIOD, period_v);
		program_reg(REG_PLAY, play_v);
		program_reg(REG_DURATION, dur_v);
	endtask

	// Offers one sample tick, with random idle cycles ahead of it, and returns
	// once the transaction has taken place.
	task automatic send_tick(input logic [MIX_W-1:0] mix, input logic frame_end);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W - MIX_W){1'b0}}, mix};
		s_tlast <= frame_end;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Stops the sender and waits for every owed sample, then lets the block settle.
	task automatic wait_for_samples(input int settle);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	function automatic logic [MIX_W-1:0] random_mix();
		if ($urandom_range(0, 1))
			return MIX_W'($urandom);
		return MIX_W'(longint'($urandom_range(0, 80000)) - 40000);
	endfunction

	// One phase of random ticks under a random tone setting.
	task automatic run_tone_phase(input idle_mode_t mode, input int count, input bit with_seed,
			input bit finite, input bit hold_once);
		logic [31:0] vol_v, step_v, per_us, period_v, play_v, start_v, dur_v;
		longint coeff_v, seed_v;
		wait_for_samples(SETTLE_CYCLES);

		if ($urandom_range(0, 5) == 0) begin
			coeff_v = $urandom_range(0, 1) ? COEFF_PEAK : -COEFF_PEAK;
			seed_v = $urandom_range(0, 1) ? SEED_PEAK : -SEED_PEAK;
		end else begin
			coeff_v = longint'($urandom_range(0, 32'(2 * COEFF_PEAK))) - COEFF_PEAK;
			seed_v = longint'($urandom_range(0, 32'(2 * SEED_PEAK))) - SEED_PEAK;
		end

		case ($urandom_range(0, 7))
			0: vol_v = 0;
			1: vol_v = 32'h000F_FFFF;
			2: vol_v = 1;
			default: vol_v = $urandom_range(VOL_RESET, VOL_PEAK);
		endcase

		case ($urandom_range(0, 9))
			0: step_v = 0;
			1: step_v = 32'h0003_FFFF;
			2: step_v = 131072;
			default: step_v = $urandom_range(20, 128) * 1024 + $urandom_range(0, 1023);
		endcase
		per_us = (step_v >> FRAC_BITS) + 1;

		// Cadence windows a few samples long, so that gaps come often.
		case ($urandom_range(0, 9))
			0: period_v = 0;
			1: period_v = 32'hFFFF_FFFF;
			default: period_v = per_us * $urandom_range(2, 16) + $urandom_range(0, per_us);
		endcase
		if ($urandom_range(0, 7) == 0)
			play_v = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
		else if (period_v == 0)
			play_v = per_us * $urandom_range(5, 60);
		else
			play_v = $urandom_range(1, period_v);

		start_v = tracker.clock_us() + per_us * $urandom_range(0, 8);
		if (finite)
			dur_v = per_us * $urandom_range(5, 40);
		else if ($urandom_range(0, 3) == 0)
			dur_v = 32'hFFFF_FFFF;
		else
			dur_v = 0;

		program_tone(coeff_v, seed_v, with_seed, vol_v, step_v, start_v, period_v, play_v,
			dur_v);
		set_idling(mode);
		for (int i = 0; i < count; i++) begin
			if (hold_once && i == count / 2)
				wait_for_samples(0);
			send_tick(random_mix(), $urandom_range(0, 7) == 0);
		end
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_COEFF;
		cfg_data = '0;
		quiet_cycles = 0;
		set_idling(IDLE_NONE);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values: mix extremes and the edges of the saturation range.
		send_tick(21'h000000, 1'b0);
		send_tick(21'h0FFFFF, 1'b0);
		send_tick(21'h100000, 1'b1);
		send_tick(MIX_W'(32767), 1'b0);
		send_tick(MIX_W'(32768), 1'b1);
		send_tick(MIX_W'(-32768), 1'b0);
		send_tick(MIX_W'(-32769), 1'b0);

		// Peak coefficient and seed: the oscillator ramps and wraps at 32 bits.
		wait_for_samples(SETTLE_CYCLES);
		program_tone(COEFF_PEAK, -SEED_PEAK, 1'b1, VOL_RESET, 131072, 0, 0, 32'hFFFF_FFFF, 0);
		for (int i = 0; i < 10; i++)
			send_tick((i % 3 == 2) ? MIX_W'(-40000) : MIX_W'(0), i == 9);

		// Zero divisor and frozen clock with the widest cadence.
		wait_for_samples(SETTLE_CYCLES);
		program_tone(-COEFF_PEAK, SEED_PEAK, 1'b1, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_tick(MIX_W'(1234), 1'b0);
		send_tick(MIX_W'(-1234), 1'b1);
		send_tick(MIX_W'(0), 1'b0);

		// Start at the current microsecond with the smallest step: a frame end
		// lands the clock right on the start time.
		wait_for_samples(SETTLE_CYCLES);
		program_tone(464943104, -134213632, 1'b1, VOL_PEAK, 1, tracker.clock_us(), 1, 1, 0);
		send_tick(MIX_W'(0), 1'b0);
		send_tick(MIX_W'(100), 1'b1);
		send_tick(MIX_W'(-100), 1'b0);
		send_tick(MIX_W'(5), 1'b0);

		// Latest start, no play window: the tone stays silent.
		wait_for_samples(SETTLE_CYCLES);
		program_tone(COEFF_PEAK, 0, 1'b0, VOL_RESET, STEP_RESET, 32'hFFFF_FFFF, 1, 0,
			32'hFFFF_FFFF);
		send_tick(MIX_W'(777), 1'b0);
		send_tick(MIX_W'(-777), 1'b1);

		// Random phases; the tone is let run out only in the last one.
		for (int ph = 0; ph < 8; ph++)
			run_tone_phase(idle_mode_t'(ph % 4), PHASE_ITEMS, ph % 2 == 0, 1'b0, ph == 2);
		run_tone_phase(IDLE_BOTH, PHASE_ITEMS, 1'b1, 1'b1, 1'b0);

		wait_for_samples(SETTLE_CYCLES);
		if (tracker.fail_count == 0 && tracker.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
